/* rtl/edit_distance_engine_assert.svh */
// ----------------------------------------------------------------------------
// Edit distance engine assertion macros
// Shared property wrappers for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef EDIT_DISTANCE_ENGINE_ASSERT_SVH
`define EDIT_DISTANCE_ENGINE_ASSERT_SVH

// checked only while out of reset
`define ED_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("edit_distance_engine: check failed");

// checked on every edge, reset included
`define ED_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("edit_distance_engine: reset check failed");

`endif

/* rtl/ed_pkg.sv */
// ----------------------------------------------------------------------------
// Edit distance engine package
// Types and fixed constants shared by the engine's modules.
// ----------------------------------------------------------------------------
package ed_pkg;

  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 16;
  localparam int ROW_W       = 12;
  localparam int STORE_DEPTH = 2048;
  localparam int STORE_AW    = 11;
  localparam int ROW_DEPTH   = 1025;
  localparam int ROW_AW      = 11;

  localparam logic [LEN_W-1:0] LEN_MAX       = 16'hFFFF;
  localparam logic [LEN_W-1:0] LEN_STORE_LIM = 16'(STORE_DEPTH);
  localparam logic [LEN_W-1:0] LEN_ROW_LIM   = 16'(ROW_DEPTH - 1);

  localparam logic SEL_FIRST  = 1'b0;
  localparam logic SEL_SECOND = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL
  } ed_state_t;

  typedef struct packed {
    logic [ROW_W-1:0]  above;
    logic [ROW_W-1:0]  left;
    logic [ROW_W-1:0]  diag;
    logic [CHAR_W-1:0] lng_char;
    logic [CHAR_W-1:0] sht_char;
  } ed_cell_in_t;

endpackage

/* rtl/ed_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port, one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module ed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/ed_cell.sv */
// ----------------------------------------------------------------------------
// Edit distance cell unit
// Min of delete, insert and substitute cost for one table cell.
// ----------------------------------------------------------------------------
module ed_cell (
  input  ed_pkg::ed_cell_in_t          cell_in,
  output logic [ed_pkg::ROW_W-1:0]     cell_min
);

  logic [ed_pkg::ROW_W:0] del_cost;
  logic [ed_pkg::ROW_W:0] ins_cost;
  logic [ed_pkg::ROW_W:0] sub_cost;
  logic [ed_pkg::ROW_W:0] min_di;
  logic [ed_pkg::ROW_W:0] min_all;
  logic                   mismatch;

  always_comb begin
    mismatch = (cell_in.lng_char != cell_in.sht_char);
    del_cost = {1'b0, cell_in.above} + 13'd1;
    ins_cost = {1'b0, cell_in.left} + 13'd1;
    sub_cost = {1'b0, cell_in.diag} + {12'd0, mismatch};
    min_di   = (del_cost < ins_cost) ? del_cost : ins_cost;
    min_all  = (sub_cost < min_di) ? sub_cost : min_di;
  end

  assign cell_min = min_all[ed_pkg::ROW_W-1:0];

endmodule

/* rtl/edit_distance_engine.sv */
// ----------------------------------------------------------------------------
// Edit distance engine
// Levenshtein distance of two byte strings with a single-row table walk.
// ----------------------------------------------------------------------------
// Characters load one per cycle while busy is low: first string, then second.
// The second string's last_char item starts the job. When the pair is over the
// length limit, or either string is empty, the result strobes the next cycle.
// Otherwise the walk runs one table cell per cycle through the shared cell unit
// and the row memory, with a row-start state ahead of each row of the longer
// string; busy stays high throughout, then out_valid pulses for
// one cycle. The receiver cannot stall; out_valid is never held.
// ----------------------------------------------------------------------------
module edit_distance_engine #(
  parameter int MAX_TOTAL_CHARS = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_string_sel,
  input  logic [ed_pkg::CHAR_W-1:0]   in_char_code,
  input  logic                        in_has_char,
  input  logic                        in_last_char,
  output logic                        out_valid,
  output logic [ed_pkg::LEN_W-1:0]    out_distance,
  output logic                        out_limit_hit
);

  localparam logic [ed_pkg::LEN_W:0] TOTAL_LIMIT = 17'(MAX_TOTAL_CHARS);

  ed_pkg::ed_state_t state_r, state_nxt;

  logic [ed_pkg::LEN_W-1:0]    first_len_r, first_len_nxt;
  logic [ed_pkg::LEN_W-1:0]    second_len_r, second_len_nxt;
  logic [ed_pkg::ROW_W-1:0]    nl_r, nl_nxt;
  logic [ed_pkg::ROW_AW-1:0]   ns_r, ns_nxt;
  logic                        swap_r, swap_nxt;
  logic [ed_pkg::ROW_W-1:0]    i_r, i_nxt;
  logic [ed_pkg::ROW_AW-1:0]   j_r, j_nxt;
  logic [ed_pkg::ROW_W-1:0]    left_r, left_nxt;
  logic [ed_pkg::ROW_W-1:0]    diag_r, diag_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ed_pkg::LEN_W-1:0]    out_distance_r, out_distance_nxt;
  logic                        out_limit_r, out_limit_nxt;

  logic                        accept;
  logic                        pair_done;
  logic                        second_inc;
  logic [ed_pkg::LEN_W-1:0]    la, lb, lmax, lmin;
  logic [ed_pkg::LEN_W:0]      total;
  logic                        over_limit;
  logic                        go_walk;
  logic                        last_cell;
  logic                        last_row;
  logic                        more_cells;

  logic                           first_wr_en, second_wr_en;
  logic                           first_rd_en, second_rd_en;
  logic [ed_pkg::STORE_AW-1:0]    first_rd_addr, second_rd_addr;
  logic [ed_pkg::CHAR_W-1:0]      first_rd_data, second_rd_data;
  logic                           lng_rd_en, sht_rd_en;
  logic [ed_pkg::STORE_AW-1:0]    lng_addr, sht_addr;
  logic                           row_wr_en, row_rd_en;
  logic [ed_pkg::ROW_AW-1:0]      row_wr_addr, row_rd_addr;
  logic [ed_pkg::ROW_W-1:0]       row_rd_data;

  ed_pkg::ed_cell_in_t            cell_in;
  logic [ed_pkg::ROW_W-1:0]       cell_min;

  assign busy   = (state_r != ed_pkg::ST_IDLE);
  assign accept = start && !busy;

  // length bookkeeping and limit decision on the starting transfer
  always_comb begin
    second_inc = (in_string_sel == ed_pkg::SEL_SECOND) && in_has_char &&
                 (second_len_r != ed_pkg::LEN_MAX);
    pair_done  = accept && (in_string_sel == ed_pkg::SEL_SECOND) && in_last_char;
    la         = first_len_r;
    lb         = second_len_r + {15'd0, second_inc};
    lmax       = (la > lb) ? la : lb;
    lmin       = (la > lb) ? lb : la;
    total      = {1'b0, la} + {1'b0, lb};
    over_limit = (total > TOTAL_LIMIT) || (lmax > ed_pkg::LEN_STORE_LIM) ||
                 (lmin > ed_pkg::LEN_ROW_LIM);
    go_walk    = !over_limit && (lmin != '0);
  end

  assign first_wr_en  = accept && (in_string_sel == ed_pkg::SEL_FIRST) && in_has_char &&
                        (first_len_r < ed_pkg::LEN_STORE_LIM);
  assign second_wr_en = accept && (in_string_sel == ed_pkg::SEL_SECOND) && in_has_char &&
                        (second_len_r < ed_pkg::LEN_STORE_LIM);

  // walk position
  always_comb begin
    last_cell  = ({1'b0, j_r} + 12'd1) == {1'b0, ns_r};
    last_row   = (i_r + 12'd1) == nl_r;
    more_cells = (state_r == ed_pkg::ST_CELL) && !last_cell;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ed_pkg::ST_IDLE: begin
        if (pair_done && go_walk) begin
          state_nxt = ed_pkg::ST_ROW;
        end
      end
      ed_pkg::ST_ROW: begin
        state_nxt = ed_pkg::ST_CELL;
      end
      ed_pkg::ST_CELL: begin
        if (last_cell) begin
          state_nxt = last_row ? ed_pkg::ST_IDLE : ed_pkg::ST_ROW;
        end
      end
      default: begin
        state_nxt = ed_pkg::ST_IDLE;
      end
    endcase
  end

  // memory controls and cell operands
  always_comb begin
    lng_rd_en   = (state_r == ed_pkg::ST_ROW);
    sht_rd_en   = (state_r == ed_pkg::ST_ROW) || more_cells;
    lng_addr    = i_r[ed_pkg::STORE_AW-1:0];
    sht_addr    = (state_r == ed_pkg::ST_ROW) ? '0 : (j_r + 11'd1);
    row_rd_en   = sht_rd_en;
    row_rd_addr = (state_r == ed_pkg::ST_ROW) ? 11'd1 : (j_r + 11'd2);
    row_wr_en   = (state_r == ed_pkg::ST_CELL);
    row_wr_addr = j_r + 11'd1;

    first_rd_en    = swap_r ? sht_rd_en : lng_rd_en;
    first_rd_addr  = swap_r ? sht_addr : lng_addr;
    second_rd_en   = swap_r ? lng_rd_en : sht_rd_en;
    second_rd_addr = swap_r ? lng_addr : sht_addr;

    cell_in.above    = (i_r == '0) ? ({1'b0, j_r} + 12'd1) : row_rd_data;
    cell_in.left     = left_r;
    cell_in.diag     = diag_r;
    cell_in.lng_char = swap_r ? second_rd_data : first_rd_data;
    cell_in.sht_char = swap_r ? first_rd_data : second_rd_data;
  end

  // register next values
  always_comb begin
    first_len_nxt    = first_len_r;
    second_len_nxt   = second_len_r;
    nl_nxt           = nl_r;
    ns_nxt           = ns_r;
    swap_nxt         = swap_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    left_nxt         = left_r;
    diag_nxt         = diag_r;
    out_valid_nxt    = 1'b0;
    out_distance_nxt = out_distance_r;
    out_limit_nxt    = out_limit_r;

    unique case (state_r)
      ed_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_string_sel == ed_pkg::SEL_FIRST) begin
            if (in_has_char && (first_len_r != ed_pkg::LEN_MAX)) begin
              first_len_nxt = first_len_r + 16'd1;
            end
          end else begin
            second_len_nxt = lb;
          end
        end
        if (pair_done) begin
          first_len_nxt  = '0;
          second_len_nxt = '0;
          nl_nxt         = lmax[ed_pkg::ROW_W-1:0];
          ns_nxt         = lmin[ed_pkg::ROW_AW-1:0];
          swap_nxt       = (lb > la);
          i_nxt          = '0;
          if (!go_walk) begin
            out_valid_nxt    = 1'b1;
            out_distance_nxt = lmax;
            out_limit_nxt    = over_limit;
          end
        end
      end
      ed_pkg::ST_ROW: begin
        left_nxt = i_r + 12'd1;
        diag_nxt = i_r;
        j_nxt    = '0;
      end
      ed_pkg::ST_CELL: begin
        left_nxt = cell_min;
        diag_nxt = cell_in.above;
        j_nxt    = j_r + 11'd1;
        if (last_cell) begin
          i_nxt = i_r + 12'd1;
          if (last_row) begin
            out_valid_nxt    = 1'b1;
            out_distance_nxt = {4'd0, cell_min};
            out_limit_nxt    = 1'b0;
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ed_pkg::ST_IDLE;
      first_len_r  <= '0;
      second_len_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_len_r  <= first_len_nxt;
      second_len_r <= second_len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nl_r           <= nl_nxt;
    ns_r           <= ns_nxt;
    swap_r         <= swap_nxt;
    i_r            <= i_nxt;
    j_r            <= j_nxt;
    left_r         <= left_nxt;
    diag_r         <= diag_nxt;
    out_distance_r <= out_distance_nxt;
    out_limit_r    <= out_limit_nxt;
  end

  ed_ram #(
    .WIDTH (ed_pkg::CHAR_W),
    .DEPTH (ed_pkg::STORE_DEPTH)
  ) u_first_store (
    .clk     (clk),
    .wr_en   (first_wr_en),
    .wr_addr (first_len_r[ed_pkg::STORE_AW-1:0]),
    .wr_data (in_char_code),
    .rd_en   (first_rd_en),
    .rd_addr (first_rd_addr),
    .rd_data (first_rd_data)
  );

  ed_ram #(
    .WIDTH (ed_pkg::CHAR_W),
    .DEPTH (ed_pkg::STORE_DEPTH)
  ) u_second_store (
    .clk     (clk),
    .wr_en   (second_wr_en),
    .wr_addr (second_len_r[ed_pkg::STORE_AW-1:0]),
    .wr_data (in_char_code),
    .rd_en   (second_rd_en),
    .rd_addr (second_rd_addr),
    .rd_data (second_rd_data)
  );

  // row entry 0 is never stored: it is the row number
  ed_ram #(
    .WIDTH (ed_pkg::ROW_W),
    .DEPTH (ed_pkg::ROW_DEPTH)
  ) u_dp_row (
    .clk     (clk),
    .wr_en   (row_wr_en),
    .wr_addr (row_wr_addr),
    .wr_data (cell_min),
    .rd_en   (row_rd_en),
    .rd_addr (row_rd_addr),
    .rd_data (row_rd_data)
  );

  ed_cell u_cell (
    .cell_in  (cell_in),
    .cell_min (cell_min)
  );

  assign out_valid     = out_valid_r;
  assign out_distance  = out_distance_r;
  assign out_limit_hit = out_limit_r;

endmodule

/* rtl/ed_checker.sv */
// ----------------------------------------------------------------------------
// Edit distance engine checker
// Port-level checks on start, busy and result strobe timing.
// ----------------------------------------------------------------------------
`include "edit_distance_engine_assert.svh"

module ed_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      in_string_sel,
  input logic [ed_pkg::CHAR_W-1:0] in_char_code,
  input logic                      in_has_char,
  input logic                      in_last_char,
  input logic                      out_valid,
  input logic [ed_pkg::LEN_W-1:0]  out_distance,
  input logic                      out_limit_hit
);

  logic start_pair;
  logic plain_load;

  assign start_pair = start && !busy && (in_string_sel == ed_pkg::SEL_SECOND) && in_last_char;
  assign plain_load = start && !busy && !((in_string_sel == ed_pkg::SEL_SECOND) && in_last_char);

  `ED_CHECK(a_pair_answers, start_pair |=> (out_valid || busy))
  `ED_CHECK(a_load_silent, plain_load |=> (!out_valid && !busy))
  `ED_CHECK(a_walk_end_result, $fell(busy) |-> out_valid)
  `ED_CHECK(a_limit_nonzero, (out_valid && out_limit_hit) |-> (out_distance != 16'd0))
  `ED_CHECK_ALWAYS(a_reset_quiet, !rst_n |=> (!busy && !out_valid))

  logic unused_ok;
  assign unused_ok = ^{in_char_code, in_has_char};

endmodule

bind edit_distance_engine ed_checker u_ed_checker (.*);
